### design/i2c_register_master_defines.svh
// i2c_register_master_defines.svh: assertion macros for the I2C register master.
// No dependencies.
`ifndef I2C_REGISTER_MASTER_DEFINES_SVH
`define I2C_REGISTER_MASTER_DEFINES_SVH
// a registered result stays put while it waits
`define IRM_ASSERT_HOLD(lbl, clk_s, rst_n, v, r, sig) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_n) \
		((v) && !(r)) |=> $stable(sig)) else $error("result changed while stalled");
// implication checked at each clock edge
`define IRM_ASSERT_IMPL(lbl, clk_s, rst_n, a, c) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_n) (a) |-> (c)) \
		else $error("implication failed");
`endif

### design/irm_pkg.sv
// irm_pkg: phase codes, segment lengths and widths for the I2C register master.
// No dependencies.
`timescale 1ns / 1ps
package irm_pkg;
	localparam int DELAY_BITS_DEF = 16;
	localparam int PROBE_LIMIT_DEF = 128;
	localparam logic [15:0] DELAY_RESET = 16'd5;

	localparam logic [2:0] PH_IDLE = 3'd0;
	localparam logic [2:0] PH_START = 3'd1;
	localparam logic [2:0] PH_TX = 3'd2;
	localparam logic [2:0] PH_ACK = 3'd3;
	localparam logic [2:0] PH_RX = 3'd4;
	localparam logic [2:0] PH_MACK = 3'd5;
	localparam logic [2:0] PH_STOP = 3'd6;
	localparam logic [2:0] PH_GAP = 3'd7;

	localparam logic [1:0] OP_READ = 2'd0;
	localparam logic [1:0] OP_BURST = 2'd1;
	localparam logic [1:0] OP_WRITE = 2'd2;
	localparam logic [1:0] OP_PROBE = 2'd3;

	typedef struct packed {
		logic scl;
		logic sda;
		logic drv;
		logic busy;
		logic rvalid;
		logic [7:0] rbyte;
		logic rlast;
		logic [2:0] acks;
		logic pfound;
		logic [6:0] faddr;
		logic done;
	} irm_res_t;

	function automatic logic [4:0] seg_len(input logic [2:0] ph);
		case (ph)
			PH_START: seg_len = 5'd3;
			PH_TX: seg_len = 5'd17;
			PH_ACK: seg_len = 5'd3;
			PH_RX: seg_len = 5'd17;
			PH_MACK: seg_len = 5'd4;
			PH_STOP: seg_len = 5'd3;
			default: seg_len = 5'd1;
		endcase
	endfunction
endpackage

### design/irm_seq.sv
// irm_seq: I2C pin sequencer state; advances one request per cycle while go is high.
// Depends on irm_pkg.
`timescale 1ns / 1ps
module irm_seq import irm_pkg::*; #(
	parameter int DELAY_BITS = DELAY_BITS_DEF,
	parameter int PROBE_LIMIT = PROBE_LIMIT_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic go,
	input logic [15:0] delay_ticks,
	input logic kind,
	input logic [1:0] op,
	input logic [6:0] device_address,
	input logic [7:0] register_address,
	input logic [7:0] write_data,
	input logic [7:0] byte_count,
	input logic sda_in,
	output irm_res_t res
);
	localparam logic [7:0] PLAST = 8'(PROBE_LIMIT - 1);

	logic [2:0] phase_q, phase_d;
	logic [DELAY_BITS-1:0] dcnt_q, dcnt_d;
	logic [4:0] step_q, step_d;
	logic [3:0] stage_q, stage_d;
	logic [7:0] shift_q, shift_d, left_q, left_d;
	logic [2:0] ack_q, ack_d;
	logic [1:0] slot_q, slot_d, lop_q, lop_d;
	logic [6:0] pnext_q, pnext_d, dev_q, dev_d;
	logic [7:0] reg_q, reg_d, dat_q, dat_d;
	logic found_q, found_d;
	logic [DELAY_BITS-1:0] lim;
	logic [DELAY_BITS-1:0] dinc;
	logic [2:0] bidx;
	irm_res_t r;

	always_comb begin
		phase_d = phase_q; dcnt_d = dcnt_q; step_d = step_q; stage_d = stage_q;
		shift_d = shift_q; left_d = left_q; ack_d = ack_q; slot_d = slot_q;
		lop_d = lop_q; pnext_d = pnext_q; dev_d = dev_q; reg_d = reg_q;
		dat_d = dat_q; found_d = found_q;
		r = '0;
		bidx = step_q[3:1];
		lim = DELAY_BITS'(delay_ticks);
		if (lim == '0) lim = DELAY_BITS'(1);
		dinc = dcnt_q + DELAY_BITS'(1);
		if (!kind) begin
			if (phase_q == PH_IDLE) begin
				lop_d = op; dev_d = device_address; reg_d = register_address;
				dat_d = write_data;
				left_d = (op == OP_READ) ? 8'd1 : ((op == OP_BURST) ? byte_count : 8'd0);
				ack_d = '0; pnext_d = '0; found_d = 1'b0; stage_d = '0; dcnt_d = '0;
				phase_d = PH_START; step_d = '0; shift_d = '0;
			end
		end else if (phase_q != PH_IDLE) begin
			dcnt_d = dinc;
			if (dinc >= lim) begin
				dcnt_d = '0;
				if (phase_q == PH_RX && step_q[0]) begin
					shift_d[3'd7 - bidx] = sda_in;
					if (step_q == 5'd15) begin
						r.rvalid = 1'b1;
						r.rbyte = shift_d;
						r.rlast = (left_q == 8'd1);
					end
				end else if (phase_q == PH_ACK && step_q == 5'd1) begin
					ack_d[slot_q] = sda_in;
				end
				step_d = step_q + 5'd1;
				if (step_d >= seg_len(phase_q)) begin
					stage_d = stage_q + 4'd1;
					step_d = '0;
					if (lop_q == OP_READ || lop_q == OP_BURST) begin
						case (stage_d)
							4'd1: begin phase_d = PH_TX; shift_d = {dev_q, 1'b0}; end
							4'd2: begin phase_d = PH_ACK; slot_d = 2'd0; end
							4'd3: begin phase_d = PH_TX; shift_d = reg_q; end
							4'd4: begin phase_d = PH_ACK; slot_d = 2'd1; end
							4'd5: begin phase_d = PH_START; shift_d = '0; end
							4'd6: begin phase_d = PH_TX; shift_d = {dev_q, 1'b1}; end
							4'd7: begin phase_d = PH_ACK; slot_d = 2'd2; end
							4'd8: begin
								shift_d = '0;
								if (left_q != '0) phase_d = PH_RX;
								else begin stage_d = 4'd10; phase_d = PH_STOP; end
							end
							4'd9: begin phase_d = PH_MACK; shift_d = '0; end
							4'd10: begin
								shift_d = '0;
								left_d = left_q - 8'd1;
								if (left_d != '0) begin stage_d = 4'd8; phase_d = PH_RX; end
								else phase_d = PH_STOP;
							end
							default: begin phase_d = PH_IDLE; r.done = 1'b1; end
						endcase
					end else if (lop_q == OP_WRITE) begin
						case (stage_d)
							4'd1: begin phase_d = PH_TX; shift_d = {dev_q, 1'b0}; end
							4'd2: begin phase_d = PH_ACK; slot_d = 2'd0; end
							4'd3: begin phase_d = PH_TX; shift_d = reg_q; end
							4'd4: begin phase_d = PH_ACK; slot_d = 2'd1; end
							4'd5: begin phase_d = PH_TX; shift_d = dat_q; end
							4'd6: begin phase_d = PH_ACK; slot_d = 2'd2; end
							4'd7: begin phase_d = PH_STOP; shift_d = '0; end
							default: begin phase_d = PH_IDLE; r.done = 1'b1; end
						endcase
					end else begin
						case (stage_d)
							4'd1: begin phase_d = PH_TX; shift_d = {pnext_q, 1'b0}; end
							4'd2: begin phase_d = PH_ACK; slot_d = 2'd0; end
							4'd3: begin
								found_d = !ack_d[0]; phase_d = PH_STOP; shift_d = '0;
							end
							4'd4: begin
								if (found_q || {1'b0, pnext_q} >= PLAST) begin
									phase_d = PH_IDLE; r.done = 1'b1;
									r.pfound = found_q;
									r.faddr = found_q ? pnext_q : 7'd0;
									stage_d = stage_q + 4'd1;
								end else begin
									pnext_d = pnext_q + 7'd1; phase_d = PH_GAP; shift_d = '0;
								end
							end
							default: begin stage_d = '0; phase_d = PH_START; shift_d = '0; end
						endcase
					end
				end
			end
		end
		// pin levels after this request
		r.scl = 1'b1; r.sda = 1'b1; r.drv = 1'b1;
		case (phase_d)
			PH_START: begin r.scl = step_d < 5'd2; r.sda = step_d == 5'd0; end
			PH_TX: begin
				if (step_d == '0) begin r.scl = 1'b0; r.sda = 1'b0; end
				else begin
					r.scl = !step_d[0];
					r.sda = shift_d[3'd7 - 3'((step_d - 5'd1) >> 1)];
				end
			end
			PH_ACK: begin
				if (step_d == '0) begin r.scl = 1'b0; r.sda = shift_d[0]; end
				else begin r.scl = step_d == 5'd1; r.drv = 1'b0; end
			end
			PH_RX: begin r.scl = (step_d != '0) && step_d[0]; r.drv = 1'b0; end
			PH_MACK: begin
				r.scl = step_d == 5'd2;
				r.sda = (step_d != '0) && (left_d == 8'd1);
			end
			PH_STOP: begin r.scl = step_d != '0; r.sda = step_d == 5'd2; end
			default: ;
		endcase
		r.busy = phase_d != PH_IDLE;
		r.acks = ack_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE; dcnt_q <= '0; step_q <= '0; stage_q <= '0;
			shift_q <= '0; left_q <= '0; ack_q <= '0; slot_q <= '0; lop_q <= '0;
			pnext_q <= '0; dev_q <= '0; reg_q <= '0; dat_q <= '0; found_q <= 1'b0;
		end else if (go) begin
			phase_q <= phase_d; dcnt_q <= dcnt_d; step_q <= step_d; stage_q <= stage_d;
			shift_q <= shift_d; left_q <= left_d; ack_q <= ack_d; slot_q <= slot_d;
			lop_q <= lop_d; pnext_q <= pnext_d; dev_q <= dev_d; reg_q <= reg_d;
			dat_q <= dat_d; found_q <= found_d;
		end
	end

	assign res = r;
endmodule

### design/i2c_register_master.sv
// i2c_register_master: top level, input register, sequencer and result register.
// Depends on irm_pkg, irm_seq and i2c_register_master_defines.svh.
//  channel | handshake              | payload
//  cfg     | cfg_valid/cfg_ready    | cfg_data (delay_ticks)
//  in      | in_valid/in_ready      | kind, op, addresses, data, count, sda_in
//  out     | out_valid/out_ready    | pin levels, status, read byte, acks, probe
// One request per cycle while results are taken: input register, one state update, result register.
// A request passes through the input register and then the result register.
// Reset clears all control state; delay_ticks returns to 5.
// The input stage stalls only when the result register is full and not taken.
`timescale 1ns / 1ps
`include "i2c_register_master_defines.svh"
module i2c_register_master import irm_pkg::*; #(
	parameter int DELAY_BITS = DELAY_BITS_DEF,
	parameter int PROBE_LIMIT = PROBE_LIMIT_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [15:0] cfg_data,
	input logic in_valid,
	output logic in_ready,
	input logic kind,
	input logic [1:0] op,
	input logic [6:0] device_address,
	input logic [7:0] register_address,
	input logic [7:0] write_data,
	input logic [7:0] byte_count,
	input logic sda_in,
	output logic out_valid,
	input logic out_ready,
	output logic scl_level,
	output logic sda_level,
	output logic sda_drive,
	output logic busy_res,
	output logic read_valid,
	output logic [7:0] read_byte,
	output logic read_last,
	output logic [2:0] ack_flags,
	output logic probe_found,
	output logic [6:0] found_address,
	output logic done_res
);
	logic [15:0] delay_q;
	logic v_s1, v_s2;
	logic kind_s1, sda_s1;
	logic [1:0] op_s1;
	logic [6:0] dev_s1;
	logic [7:0] reg_s1, dat_s1, cnt_s1;
	logic adv_s1;
	irm_res_t res, res_s2;

	assign cfg_ready = 1'b1;
	assign adv_s1 = v_s1 && (!v_s2 || out_ready);
	assign in_ready = !v_s1 || adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) delay_q <= DELAY_RESET;
		else if (cfg_valid) delay_q <= cfg_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (in_ready) v_s1 <= in_valid;
			if (adv_s1) v_s2 <= 1'b1;
			else if (out_ready) v_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			kind_s1 <= kind; op_s1 <= op; dev_s1 <= device_address;
			reg_s1 <= register_address; dat_s1 <= write_data; cnt_s1 <= byte_count;
			sda_s1 <= sda_in;
		end
		if (adv_s1) res_s2 <= res;
	end

	irm_seq #(.DELAY_BITS(DELAY_BITS), .PROBE_LIMIT(PROBE_LIMIT)) u_seq (
		.clk(clk), .arst_n(arst_n), .go(adv_s1), .delay_ticks(delay_q),
		.kind(kind_s1), .op(op_s1), .device_address(dev_s1),
		.register_address(reg_s1), .write_data(dat_s1), .byte_count(cnt_s1),
		.sda_in(sda_s1), .res(res)
	);

	assign out_valid = v_s2;
	assign scl_level = res_s2.scl;
	assign sda_level = res_s2.sda;
	assign sda_drive = res_s2.drv;
	assign busy_res = res_s2.busy;
	assign read_valid = res_s2.rvalid;
	assign read_byte = res_s2.rbyte;
	assign read_last = res_s2.rlast;
	assign ack_flags = res_s2.acks;
	assign probe_found = res_s2.pfound;
	assign found_address = res_s2.faddr;
	assign done_res = res_s2.done;

	`IRM_ASSERT_HOLD(a_out_hold, clk, arst_n, out_valid, out_ready, res_s2)
	`IRM_ASSERT_IMPL(a_done_idle, clk, arst_n, out_valid && done_res, !busy_res)
	`IRM_ASSERT_IMPL(a_last_valid, clk, arst_n, out_valid && read_last, read_valid)
	`IRM_ASSERT_IMPL(a_found_done, clk, arst_n, out_valid && probe_found, done_res)
endmodule
